### sv/tkst_pkg.sv
package tkst_pkg;

  // Table size and the widths that follow from it.
  localparam int TABLE_DEPTH = 10;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int RANK_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Fixed field widths of the stream items.
  localparam int SCORE_W    = 32;
  localparam int TAG_W      = 16;
  localparam int IDX_W      = 4;
  localparam int OUT_RANK_W = 4;
  localparam int OUT_CNT_W  = 4;
  localparam int S_DATA_W   = 56;
  localparam int M_DATA_W   = 64;

  // Operation codes carried in the input tuser bit.
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [TAG_W-1:0]          tag_t;

  // One input item as held in the input register.
  typedef struct packed {
    logic             func;
    score_t           new_score;
    tag_t             player_tag;
    logic [IDX_W-1:0] entry_index;
  } item_t;

  // One result item as computed by the table.
  typedef struct packed {
    logic                  accepted;
    logic [OUT_RANK_W-1:0] placed_rank;
    logic [OUT_CNT_W-1:0]  entry_count;
    logic                  read_valid;
    score_t                read_score;
    tag_t                  read_tag;
  } result_t;

endpackage

### sv/tkst_table.sv
module tkst_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  tkst_pkg::item_t   item,
  output tkst_pkg::result_t result
);
  import tkst_pkg::*;

  score_t           score_store [TABLE_DEPTH];
  tag_t             tag_store   [TABLE_DEPTH];
  logic [CNT_W-1:0] valid_count;
  logic [CNT_W-1:0] valid_count_next;

  logic [TABLE_DEPTH-1:0] ge;
  logic [TABLE_DEPTH-1:0] ins;
  logic                   room;
  logic                   take;
  logic [RANK_W-1:0]      pos;
  logic [31:0]            pos_wide;
  logic [31:0]            cnt_wide;
  score_t                 sel_score;
  tag_t                   sel_tag;
  logic                   idx_ok;

  // Compare the new score against every stored entry in parallel.
  // Valid entries are sorted, so ge is a run of ones from slot zero.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ge[i] = (32'(i) < 32'(valid_count)) && (score_store[i] >= item.new_score);
    end
  end

  // The insert slot is the first slot past the run of ones.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == 0) begin
        ins[i] = !ge[i];
      end else begin
        ins[i] = !ge[i] && ge[i-1];
      end
    end
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (ins[i]) begin
        pos = pos | RANK_W'(i);
      end
    end
  end

  // A full table only takes a score strictly above its last entry.
  assign room = 32'(valid_count) < 32'(TABLE_DEPTH);
  assign take = (item.func == FUNC_INSERT) &&
                (room || (item.new_score > score_store[TABLE_DEPTH-1]));

  always_comb begin
    valid_count_next = valid_count;
    if (take && room) begin
      valid_count_next = valid_count + CNT_W'(1);
    end
  end

  // Read selection at the requested index.
  assign idx_ok = (item.func == FUNC_READ) && (32'(item.entry_index) < 32'(valid_count));

  always_comb begin
    sel_score = '0;
    sel_tag   = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (32'(item.entry_index) == 32'(i)) begin
        sel_score = score_store[i];
        sel_tag   = tag_store[i];
      end
    end
  end

  // Result fields; rank and count are cut to their port width.
  assign pos_wide = 32'(pos);
  assign cnt_wide = 32'(valid_count_next);

  always_comb begin
    result             = '0;
    result.accepted    = take;
    result.placed_rank = take ? pos_wide[OUT_RANK_W-1:0] : '0;
    result.entry_count = cnt_wide[OUT_CNT_W-1:0];
    result.read_valid  = idx_ok;
    result.read_score  = idx_ok ? sel_score : '0;
    result.read_tag    = idx_ok ? sel_tag : '0;
  end

  // Entry update: slots above the insert point hold, the insert slot
  // takes the new entry, and slots below it shift down by one.
  always_ff @(posedge clk) begin
    if (advance && take) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (ins[i]) begin
          score_store[i] <= item.new_score;
          tag_store[i]   <= item.player_tag;
        end else if (!ge[i] && (i > 0)) begin
          score_store[i] <= score_store[(i > 0) ? i - 1 : 0];
          tag_store[i]   <= tag_store[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_count <= '0;
    end else if (advance) begin
      valid_count <= valid_count_next;
    end
  end

endmodule

### sv/top_k_sorted_score_table.sv
// Top-k sorted score table with stream input and output.
// Pipeline: an accepted input transaction is held in the input register, and its result
// goes to the result register, which drives m_tdata; m_tready low stalls both stages.
// Throughput: one transaction per cycle while the output is not stalled; the parallel
// compare and shift of the entry registers is combinational after the input register.
// Reset: rst is synchronous and active high; it empties the table and both stages.
module top_k_sorted_score_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata from bit 0: new_score[31:0], player_tag[47:32], entry_index[51:48], zeros.
  input  logic [tkst_pkg::S_DATA_W-1:0] s_tdata,
  // s_tuser: func.
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata from bit 0: accepted[0], placed_rank[4:1], entry_count[8:5],
  // read_valid[9], read_score[41:10], read_tag[57:42], zeros.
  output logic [tkst_pkg::M_DATA_W-1:0] m_tdata
);
  import tkst_pkg::*;

  item_t   item;
  logic    item_valid;
  result_t result;
  result_t result_q;
  logic    out_free;
  logic    advance;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = item_valid && out_free;
  assign s_tready = !item_valid || out_free;

  // Input register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.func        <= s_tuser;
      item.new_score   <= s_tdata[31:0];
      item.player_tag  <= s_tdata[47:32];
      item.entry_index <= s_tdata[51:48];
    end
  end

  // Table compare and update.
  tkst_table u_table (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .result  (result)
  );

  // Result register stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign m_tdata = {6'b0, result_q.read_tag, result_q.read_score, result_q.read_valid,
                    result_q.entry_count, result_q.placed_rank, result_q.accepted};

endmodule
